// ===== rtl/avdf_pkg.sv =====
// shared types and constants for the audio volume dac formatter
package avdf_pkg;

  // output format selection, code 3 is unused and behaves as pass-through
  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_SPK  = 2'd1,
    MODE_EXT  = 2'd2
  } out_mode_e;

  // configuration register indexes
  localparam logic [1:0] REG_OUTPUT_MODE    = 2'd0;
  localparam logic [1:0] REG_VOLUME_PERCENT = 2'd1;
  localparam logic [1:0] REG_MUTED          = 2'd2;

  localparam int unsigned VolW  = 7;
  localparam int unsigned CfgW  = 7;

  // reset values of the registers
  localparam logic [1:0]      RESET_MODE   = 2'd1;
  localparam logic [VolW-1:0] RESET_VOLUME = 7'd50;

  // speaker path gain and dac split
  localparam logic [7:0]  SPK_GAIN   = 8'd254;
  localparam logic [10:0] DAC_LIMIT  = 11'd127;
  localparam logic [7:0]  DAC_OFFSET = 8'h80;

  // reciprocals of 100: ceil(2^22/100) for the speaker path (after the
  // >>15 that removes the 32768 factor), ceil(2^29/100) for the external path
  localparam logic [15:0] RECIP_SPK       = 16'd41944;
  localparam int unsigned RECIP_SPK_SHIFT = 22;
  localparam logic [22:0] RECIP_EXT       = 23'd5368710;
  localparam int unsigned RECIP_EXT_SHIFT = 29;

endpackage

// ===== rtl/avdf_spk_fmt.sv =====
// speaker dac formatter: signed range split into main and overflow bytes
module avdf_spk_fmt (
  input  logic [9:0]  range_mag_i,
  input  logic        range_neg_i,
  output logic [15:0] word_ovf_o,
  output logic [15:0] word_main_o
);

  logic signed [10:0] rng;
  logic signed [10:0] dac0;
  logic signed [10:0] dac1;
  logic signed [10:0] lim;

  assign lim = $signed(avdf_pkg::DAC_LIMIT);

  always_comb begin
    rng = range_neg_i ? -$signed({1'b0, range_mag_i}) : $signed({1'b0, range_mag_i});
    if (rng > lim) begin
      dac1 = rng - lim;
      dac0 = lim;
    end else if (rng < -lim) begin
      dac1 = rng + lim;
      dac0 = -lim;
    end else begin
      dac1 = '0;
      dac0 = rng;
    end
  end

  // only the low byte survives the shift into the upper half of the word
  assign word_ovf_o  = {dac1[7:0] - avdf_pkg::DAC_OFFSET, 8'h00};
  assign word_main_o = {dac0[7:0] + avdf_pkg::DAC_OFFSET, 8'h00};

endmodule

// ===== rtl/audio_volume_dac_formatter_top.sv =====
// top level of the audio volume dac formatter pipeline
// a taken transaction passes the s1, s2, s3 and output registers before done_o goes high
// throughput: one stereo frame per cycle, set by the four-stage pipeline
// busy_o is held low, the pipeline never stalls and the receiver cannot stall it
// reset: output_mode=1, volume_percent=50, muted=0, pipeline valid bits cleared
// config writes are expected only while no transaction is in flight
module audio_volume_dac_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] left_sample_i,
  input  logic [15:0] right_sample_i,
  input  logic        end_of_buffer_i,
  // result channel
  output logic        done_o,
  output logic [15:0] out_left_o,
  output logic [15:0] out_right_o,
  output logic        end_of_buffer_out_o,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [avdf_pkg::CfgW-1:0] cfg_wdata_i
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0] mode_q;
  logic [6:0] volume_q;
  logic       muted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= avdf_pkg::RESET_MODE;
      volume_q <= avdf_pkg::RESET_VOLUME;
      muted_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        avdf_pkg::REG_OUTPUT_MODE:    mode_q   <= cfg_wdata_i[1:0];
        avdf_pkg::REG_VOLUME_PERCENT: volume_q <= cfg_wdata_i;
        avdf_pkg::REG_MUTED:          muted_q  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // no backpressure anywhere, a new frame can enter every cycle
  assign busy_o = 1'b0;

  logic take;
  assign take = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // stage 1: mono downmix, magnitudes and signs, effective volume
  // ---------------------------------------------------------------------------
  logic [16:0] sum;
  logic [15:0] mono;
  logic [6:0]  vol_eff;
  logic [14:0] vol_gain;

  assign sum      = {left_sample_i[15], left_sample_i} + {right_sample_i[15], right_sample_i};
  assign mono     = sum[16:1];   // arithmetic shift right by one, floor
  assign vol_eff  = muted_q ? '0 : volume_q;
  assign vol_gain = 15'(vol_eff) * 15'(avdf_pkg::SPK_GAIN);

  // magnitude of a 16-bit two's complement value, 0x8000 maps to 32768
  function automatic logic [15:0] mag16(input logic [15:0] v);
    mag16 = v[15] ? (~v + 16'd1) : v;
  endfunction

  logic        s1_valid_q;
  logic [1:0]  s1_mode_q;
  logic        s1_eob_q;
  logic [15:0] s1_left_q, s1_right_q;
  logic [15:0] s1_mag_l_q, s1_mag_r_q, s1_mag_m_q;
  logic        s1_neg_l_q, s1_neg_r_q, s1_neg_m_q;
  logic [6:0]  s1_vol_q;
  logic [14:0] s1_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q  <= mode_q;
    s1_eob_q   <= end_of_buffer_i;
    s1_left_q  <= left_sample_i;
    s1_right_q <= right_sample_i;
    s1_mag_l_q <= mag16(left_sample_i);
    s1_mag_r_q <= mag16(right_sample_i);
    s1_mag_m_q <= mag16(mono);
    s1_neg_l_q <= left_sample_i[15];
    s1_neg_r_q <= right_sample_i[15];
    s1_neg_m_q <= mono[15];
    s1_vol_q   <= vol_eff;
    s1_gain_q  <= vol_gain;
  end

  // ---------------------------------------------------------------------------
  // stage 2: volume products on magnitudes
  // ---------------------------------------------------------------------------
  logic [30:0] prod_m;
  logic [22:0] prod_l, prod_r;

  assign prod_m = 31'(s1_mag_m_q) * 31'(s1_gain_q);
  assign prod_l = 23'(s1_mag_l_q) * 23'(s1_vol_q);
  assign prod_r = 23'(s1_mag_r_q) * 23'(s1_vol_q);

  logic        s2_valid_q;
  logic [1:0]  s2_mode_q;
  logic        s2_eob_q;
  logic [15:0] s2_left_q, s2_right_q;
  logic [15:0] s2_pm_q;   // product divided by 32768
  logic [22:0] s2_pl_q, s2_pr_q;
  logic        s2_neg_l_q, s2_neg_r_q, s2_neg_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_mode_q  <= s1_mode_q;
    s2_eob_q   <= s1_eob_q;
    s2_left_q  <= s1_left_q;
    s2_right_q <= s1_right_q;
    s2_pm_q    <= prod_m[30:15];
    s2_pl_q    <= prod_l;
    s2_pr_q    <= prod_r;
    s2_neg_l_q <= s1_neg_l_q;
    s2_neg_r_q <= s1_neg_r_q;
    s2_neg_m_q <= s1_neg_m_q;
  end

  // ---------------------------------------------------------------------------
  // stage 3: divide by 100 through reciprocal multiply, exact over the range
  // ---------------------------------------------------------------------------
  logic [31:0] quo_m_full;
  logic [45:0] quo_l_full, quo_r_full;

  assign quo_m_full = 32'(s2_pm_q) * 32'(avdf_pkg::RECIP_SPK);
  assign quo_l_full = 46'(s2_pl_q) * 46'(avdf_pkg::RECIP_EXT);
  assign quo_r_full = 46'(s2_pr_q) * 46'(avdf_pkg::RECIP_EXT);

  logic        s3_valid_q;
  logic [1:0]  s3_mode_q;
  logic        s3_eob_q;
  logic [15:0] s3_left_q, s3_right_q;
  logic [9:0]  s3_qm_q;
  logic [16:0] s3_ql_q, s3_qr_q;
  logic        s3_neg_l_q, s3_neg_r_q, s3_neg_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_mode_q  <= s2_mode_q;
    s3_eob_q   <= s2_eob_q;
    s3_left_q  <= s2_left_q;
    s3_right_q <= s2_right_q;
    s3_qm_q    <= quo_m_full[avdf_pkg::RECIP_SPK_SHIFT +: 10];
    s3_ql_q    <= quo_l_full[avdf_pkg::RECIP_EXT_SHIFT +: 17];
    s3_qr_q    <= quo_r_full[avdf_pkg::RECIP_EXT_SHIFT +: 17];
    s3_neg_l_q <= s2_neg_l_q;
    s3_neg_r_q <= s2_neg_r_q;
    s3_neg_m_q <= s2_neg_m_q;
  end

  // ---------------------------------------------------------------------------
  // stage 4: sign restore, clip or dac split, format select
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] clip_signed(input logic [16:0] q, input logic neg);
    logic signed [17:0] v;
    v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (v > 18'sd32767) begin
      clip_signed = 16'h7fff;
    end else if (v < -18'sd32768) begin
      clip_signed = 16'h8000;
    end else begin
      clip_signed = v[15:0];
    end
  endfunction

  logic [15:0] spk_ovf_word, spk_main_word;

  avdf_spk_fmt u_spk_fmt (
    .range_mag_i (s3_qm_q),
    .range_neg_i (s3_neg_m_q),
    .word_ovf_o  (spk_ovf_word),
    .word_main_o (spk_main_word)
  );

  logic [15:0] left_d, right_d;

  always_comb begin
    case (s3_mode_q)
      avdf_pkg::MODE_SPK: begin
        left_d  = spk_ovf_word;
        right_d = spk_main_word;
      end
      avdf_pkg::MODE_EXT: begin
        left_d  = clip_signed(s3_ql_q, s3_neg_l_q);
        right_d = clip_signed(s3_qr_q, s3_neg_r_q);
      end
      default: begin
        left_d  = s3_left_q;
        right_d = s3_right_q;
      end
    endcase
  end

  logic        done_q;
  logic [15:0] out_left_q, out_right_q;
  logic        eob_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_left_q  <= left_d;
    out_right_q <= right_d;
    eob_out_q   <= s3_eob_q;
  end

  assign done_o              = done_q;
  assign out_left_o          = out_left_q;
  assign out_right_o         = out_right_q;
  assign end_of_buffer_out_o = eob_out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##4 done_o)
    else $error("accepted transaction did not complete after four cycles");

  a_eob_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (end_of_buffer_out_o == $past(end_of_buffer_i, 4)))
    else $error("end of buffer mark out of step with its transaction");

  a_spk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (s3_qm_q <= 10'd322))
    else $error("speaker range quotient out of bounds");

  a_ext_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> ((s3_ql_q <= 17'd41615) && (s3_qr_q <= 17'd41615)))
    else $error("external dac quotient out of bounds");

endmodule

// ===== tb/avdf_frame_checker.sv =====
// frame checker for the audio volume dac formatter: predicts and compares results
`timescale 1ns / 1ps

module avdf_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [15:0] left_sample_i,
  input  logic [15:0] right_sample_i,
  input  logic        end_of_buffer_i,
  input  logic        done_o,
  input  logic [15:0] out_left_o,
  input  logic [15:0] out_right_o,
  input  logic        end_of_buffer_out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        eob;
  } dac_frame_t;

  localparam longint SpkGain  = 254;
  localparam longint SpkDiv   = 3276800;
  localparam longint DacMax   = 127;
  localparam longint DacBias  = 128;
  localparam longint PcmMax   = 32767;
  localparam longint PcmMin   = -32768;

  logic [1:0]                mode_q;
  logic [avdf_pkg::VolW-1:0] vol_q;
  logic                      mute_q;
  dac_frame_t                expected_frames[$];

  function automatic logic [15:0] clip_pcm(longint x);
    longint c;
    c = x;
    if (x > PcmMax) c = PcmMax;
    if (x < PcmMin) c = PcmMin;
    return c[15:0];
  endfunction

  function automatic dac_frame_t format_frame(logic signed [15:0] l, logic signed [15:0] r,
                                              logic eob);
    dac_frame_t f;
    longint gain, mono, span, hi, lo, w_hi, w_lo;
    gain  = mute_q ? 0 : longint'(vol_q);
    f.eob = eob;
    case (mode_q)
      avdf_pkg::MODE_SPK: begin
        // floor halving of the stereo sum
        mono = (longint'(l) + longint'(r)) >>> 1;
        span = (mono * SpkGain * gain) / SpkDiv;
        if (span > DacMax) begin
          hi = span - DacMax;
          lo = DacMax;
        end else if (span < -DacMax) begin
          hi = span + DacMax;
          lo = -DacMax;
        end else begin
          hi = 0;
          lo = span;
        end
        w_hi    = (hi - DacBias) * 256;
        w_lo    = (lo + DacBias) * 256;
        f.left  = w_hi[15:0];
        f.right = w_lo[15:0];
      end
      avdf_pkg::MODE_EXT: begin
        f.left  = clip_pcm((longint'(l) * gain) / 100);
        f.right = clip_pcm((longint'(r) * gain) / 100);
      end
      default: begin
        // pass-through, the unused code too
        f.left  = l;
        f.right = r;
      end
    endcase
    return f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dac_frame_t want;
    if (!rst_ni) begin
      mode_q <= avdf_pkg::RESET_MODE;
      vol_q  <= avdf_pkg::RESET_VOLUME;
      mute_q <= 1'b0;
      expected_frames.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (done_o) begin
        if (expected_frames.size() == 0) begin
          if (errors_o < 10)
            $display("%0t: result with no transaction pending: l=%h r=%h eob=%b", $realtime,
                     out_left_o, out_right_o, end_of_buffer_out_o);
          errors_o++;
        end else begin
          want = expected_frames.pop_front();
          if (want.left !== out_left_o || want.right !== out_right_o ||
              want.eob !== end_of_buffer_out_o) begin
            if (errors_o < 10)
              $display("%0t: mismatch expected l=%h r=%h eob=%b got l=%h r=%h eob=%b",
                       $realtime, want.left, want.right, want.eob,
                       out_left_o, out_right_o, end_of_buffer_out_o);
            errors_o++;
          end
        end
      end
      if (start_i && !busy_o)
        expected_frames.push_back(format_frame(left_sample_i, right_sample_i,
                                               end_of_buffer_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          avdf_pkg::REG_OUTPUT_MODE:    mode_q <= cfg_wdata_i[1:0];
          avdf_pkg::REG_VOLUME_PERCENT: vol_q  <= cfg_wdata_i[avdf_pkg::VolW-1:0];
          avdf_pkg::REG_MUTED:          mute_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      pending_o = expected_frames.size();
    end
  end

endmodule

// ===== tb/tb_audio_volume_dac_formatter_top.sv =====
// testbench top for the audio volume dac formatter: stimulus, config phases and verdict
`timescale 1ns / 1ps

module tb_audio_volume_dac_formatter_top;

  // code 3 has no enum member, the block treats it as pass-through
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         PipeDepth   = 4;
  localparam int         RandPhases  = 10;
  localparam int         PhaseFrames = 85;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start_i         = 1'b0;
  logic [15:0] left_sample_i   = '0;
  logic [15:0] right_sample_i  = '0;
  logic        end_of_buffer_i = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [1:0]  cfg_idx_i       = '0;
  logic [6:0]  cfg_wdata_i     = '0;
  logic        busy_o;
  logic        done_o;
  logic [15:0] out_left_o;
  logic [15:0] out_right_o;
  logic        end_of_buffer_out_o;
  int          errors;
  int          pending;

  // corner frames: both rails, silence, the floor halving of odd negative sums
  logic [15:0] corner_l[6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h0001};
  logic [15:0] corner_r[6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'hFFFE};

  always #5 clk_i = ~clk_i;

  audio_volume_dac_formatter_top i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .left_sample_i       (left_sample_i),
    .right_sample_i      (right_sample_i),
    .end_of_buffer_i     (end_of_buffer_i),
    .done_o              (done_o),
    .out_left_o          (out_left_o),
    .out_right_o         (out_right_o),
    .end_of_buffer_out_o (end_of_buffer_out_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i)
  );

  avdf_frame_checker i_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .left_sample_i       (left_sample_i),
    .right_sample_i      (right_sample_i),
    .end_of_buffer_i     (end_of_buffer_i),
    .done_o              (done_o),
    .out_left_o          (out_left_o),
    .out_right_o         (out_right_o),
    .end_of_buffer_out_o (end_of_buffer_out_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .errors_o            (errors),
    .pending_o           (pending)
  );

  // all tasks are entered at a rising edge and return at a rising edge

  // present one frame and hold it until the block takes the transaction;
  // start stays high on return so frames can follow back to back
  task automatic send_frame(logic [15:0] l, logic [15:0] r, logic eob);
    logic took;
    start_i         <= 1'b1;
    left_sample_i   <= l;
    right_sample_i  <= r;
    end_of_buffer_i <= eob;
    do begin
      // busy only moves at rising edges, so the falling edge sees the value
      // that the next rising edge acts on
      @(negedge clk_i);
      took = !busy_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // sample mix: rails, values around zero, and full random words
  function automatic logic [15:0] pcm_sample();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: begin
        v = 16'($urandom_range(0, 16));
        v = v - 16'd8;
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // let every expected result come back, then give the pipe spare idle time
  task automatic drain_pipe();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (PipeDepth) @(posedge clk_i);
  endtask

  // write all three registers back to back; unused upper data bits carry noise
  // that the block must mask off
  task automatic set_config(logic [1:0] mode, logic [6:0] vol, logic mute);
    logic [6:0] junk;
    junk        = 7'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= avdf_pkg::REG_OUTPUT_MODE;
    cfg_wdata_i <= {junk[6:2], mode};
    @(posedge clk_i);
    cfg_idx_i   <= avdf_pkg::REG_VOLUME_PERCENT;
    cfg_wdata_i <= vol;
    @(posedge clk_i);
    junk        = 7'($urandom);
    cfg_idx_i   <= avdf_pkg::REG_MUTED;
    cfg_wdata_i <= {junk[6:1], mute};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // hard stop in case the block never answers
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [1:0] d_mode[6];
    logic [6:0] d_vol[6];
    logic       d_mute[6];
    int         k;
    logic [1:0] mode;
    logic [6:0] vol;
    logic       no_gaps;
    int         r;

    d_mode = '{avdf_pkg::MODE_SPK, avdf_pkg::MODE_EXT, avdf_pkg::MODE_PASS, MODE_UNUSED,
               avdf_pkg::MODE_SPK, avdf_pkg::MODE_EXT};
    d_vol  = '{7'd127, 7'd127, 7'd0, 7'd100, 7'd100, 7'd100};
    d_mute = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: corners at the reset settings, which checks the reset
    // values as well, then over-range volume, pass-through at zero volume,
    // the unused mode code and mute in the unused code, speaker and external formats
    for (int i = 0; i < 6; i++) begin
      send_frame(corner_l[i], corner_r[i], i[0]);
      idle_cycles(i % 3);
    end
    k = 0;
    for (int c = 0; c < 6; c++) begin
      drain_pipe();
      set_config(d_mode[c], d_vol[c], d_mute[c]);
      for (int i = 0; i < 3; i++) begin
        send_frame(corner_l[k % 6], corner_r[k % 6], k[1]);
        idle_cycles(k % 2);
        k++;
      end
    end

    // random part: one setting per phase, volume extremes weighted in, and
    // some phases run back to back with no gaps at all
    for (int p = 0; p < RandPhases; p++) begin
      drain_pipe();
      r = $urandom_range(0, 9);
      if (r == 0)     mode = MODE_UNUSED;
      else if (r < 3) mode = avdf_pkg::MODE_PASS;
      else if (r < 7) mode = avdf_pkg::MODE_SPK;
      else            mode = avdf_pkg::MODE_EXT;
      case ($urandom_range(0, 5))
        0:       vol = 7'd0;
        1:       vol = 7'd100;
        2:       vol = 7'd127;
        default: vol = 7'($urandom_range(0, 127));
      endcase
      set_config(mode, vol, $urandom_range(0, 4) == 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PhaseFrames; i++) begin
        send_frame(pcm_sample(), pcm_sample(), $urandom_range(0, 7) == 0);
        if (!no_gaps) idle_cycles(pick_gap());
      end
    end

    drain_pipe();

    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/avdf_pkg.sv
rtl/avdf_spk_fmt.sv
rtl/audio_volume_dac_formatter_top.sv
tb/avdf_frame_checker.sv
tb/tb_audio_volume_dac_formatter_top.sv
